### rtl/core/maf_pkg.sv
// Package for the moving average forecaster: sizes, register indexes
// and shared widths. No dependencies; used by maf_div and the top level.
package maf_pkg;

  // Sizing
  localparam int WINDOW_MAX  = 64;
  localparam int HORIZON_MAX = 64;
  localparam int PRICE_W     = 24;
  localparam int CFG_W       = 7;
  localparam int ADDR_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W       = PRICE_W + ADDR_W;
  localparam int STEP_W      = $clog2(SUM_W + 1);

  // Configuration port
  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [IDX_W-1:0] REG_HORIZON    = 2'd1;

  // Stream payload widths
  localparam int IN_DATA_W  = ((PRICE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * PRICE_W + 7) / 8) * 8;

endpackage

### rtl/core/moving_average_forecast.sv
// Moving average forecaster top level: FSM, window memory, output register.
// Depends on maf_pkg and maf_div.

// History prices are taken one per cycle into a 64-entry window memory
// while the running window sum is kept alongside. The transfer that
// completes a history of window_len prices starts a burst of horizon
// forecasts, during which in_tready is low. Each forecast passes S_START,
// which starts the divider and reads the oldest window entry, then the
// bit-serial divider (one quotient bit per cycle over the 30-bit sum), then
// the emit step in S_DIV, which writes the forecast back into the window and
// loads the output register. A burst holds the input for all its forecasts
// and while a finished forecast waits on a full output register, and the
// next history can start loading while the last forecast still waits at the
// output. A register write clears any partial history.
// The final forecast of a run has tlast set and carries the run's largest
// and smallest forecast; earlier forecasts carry zero there.
module moving_average_forecast (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [maf_pkg::IN_DATA_W-1:0]  in_tdata,   // [23:0] price
  // Result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [maf_pkg::OUT_DATA_W-1:0] out_tdata,  // [23:0] forecast,
                                                     // [47:24] max_forecast,
                                                     // [71:48] min_forecast
  output logic                           out_tlast,  // last_flag
  // Configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [maf_pkg::IDX_W-1:0]      cfg_index,
  input  logic [maf_pkg::CFG_W-1:0]      cfg_data
);

  localparam int PW = maf_pkg::PRICE_W;
  localparam int AW = maf_pkg::ADDR_W;
  localparam int CW = maf_pkg::CFG_W;
  localparam int SW = maf_pkg::SUM_W;

  // FSM codes
  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] win_len_r, win_len_nxt;
  logic [CW-1:0] horizon_r, horizon_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] fc_cnt_r, fc_cnt_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [PW-1:0] max_r, max_nxt;
  logic [PW-1:0] min_r, min_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_last_r, out_last_nxt;
  logic [PW-1:0] out_fc_r, out_fc_nxt;
  logic [PW-1:0] out_max_r, out_max_nxt;
  logic [PW-1:0] out_min_r, out_min_nxt;

  // Window memory
  logic [PW-1:0] win_mem [maf_pkg::WINDOW_MAX];
  logic          mem_we;
  logic [PW-1:0] mem_wdata;
  logic          mem_re;
  logic [PW-1:0] rd_data_r;

  logic [CW-1:0] eff_w, eff_h;
  logic [AW:0]   wp_ext;
  logic [AW-1:0] wp_adv;
  logic [CW-1:0] cnt_inc, fc_inc;
  logic          hist_done, fc_last;
  logic          in_xfer, cfg_xfer, out_free, emit;
  logic          div_start, div_done;
  logic [PW-1:0] div_q;
  logic [PW-1:0] new_max, new_min;

  // Effective window length and horizon
  always_comb begin
    if (win_len_r == '0) begin
      eff_w = CW'(1);
    end else if (32'(win_len_r) > maf_pkg::WINDOW_MAX) begin
      eff_w = CW'(maf_pkg::WINDOW_MAX);
    end else begin
      eff_w = win_len_r;
    end
    if (horizon_r == '0) begin
      eff_h = CW'(1);
    end else if (32'(horizon_r) > maf_pkg::HORIZON_MAX) begin
      eff_h = CW'(maf_pkg::HORIZON_MAX);
    end else begin
      eff_h = horizon_r;
    end
  end

  // Ring pointer advance and counters
  always_comb begin
    wp_ext    = {1'b0, wp_r} + 1'b1;
    wp_adv    = (wp_ext == (AW+1)'(eff_w)) ? '0 : wp_ext[AW-1:0];
    cnt_inc   = cnt_r + 1'b1;
    fc_inc    = fc_cnt_r + 1'b1;
    hist_done = (cnt_inc == eff_w);
    fc_last   = (fc_inc == eff_h);
  end

  assign in_tready = (state_r == S_LOAD);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_tready;
  assign emit      = (state_r == S_DIV) && div_done && out_free;
  assign div_start = (state_r == S_START);

  // Running extremes including the forecast being emitted
  always_comb begin
    if (fc_cnt_r == '0) begin
      new_max = div_q;
      new_min = div_q;
    end else begin
      new_max = (div_q > max_r) ? div_q : max_r;
      new_min = (div_q < min_r) ? div_q : min_r;
    end
  end

  // Main control
  always_comb begin
    state_nxt     = state_r;
    win_len_nxt   = win_len_r;
    horizon_nxt   = horizon_r;
    cnt_nxt       = cnt_r;
    fc_cnt_nxt    = fc_cnt_r;
    wp_nxt        = wp_r;
    sum_nxt       = sum_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_fc_nxt    = out_fc_r;
    out_max_nxt   = out_max_r;
    out_min_nxt   = out_min_r;
    mem_we        = 1'b0;
    mem_wdata     = in_tdata[PW-1:0];
    mem_re        = 1'b0;

    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          mem_we  = 1'b1;
          sum_nxt = sum_r + SW'(in_tdata[PW-1:0]);
          wp_nxt  = wp_adv;
          cnt_nxt = cnt_inc;
          if (hist_done) begin
            fc_cnt_nxt = '0;
            state_nxt  = S_START;
          end
        end
      end
      S_START: begin
        // divider starts on sum_r, oldest entry read at wp_r
        mem_re    = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (emit) begin
          mem_we        = 1'b1;
          mem_wdata     = div_q;
          sum_nxt       = sum_r - SW'(rd_data_r) + SW'(div_q);
          wp_nxt        = wp_adv;
          max_nxt       = new_max;
          min_nxt       = new_min;
          out_valid_nxt = 1'b1;
          out_fc_nxt    = div_q;
          out_last_nxt  = fc_last;
          out_max_nxt   = fc_last ? new_max : '0;
          out_min_nxt   = fc_last ? new_min : '0;
          if (fc_last) begin
            cnt_nxt    = '0;
            wp_nxt     = '0;
            sum_nxt    = '0;
            fc_cnt_nxt = '0;
            state_nxt  = S_LOAD;
          end else begin
            fc_cnt_nxt = fc_inc;
            state_nxt  = S_START;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // Register writes drop any partial history
    if (cfg_xfer) begin
      case (cfg_index)
        maf_pkg::REG_WINDOW_LEN: begin
          win_len_nxt = cfg_data;
          cnt_nxt     = '0;
          wp_nxt      = '0;
          sum_nxt     = '0;
        end
        maf_pkg::REG_HORIZON: begin
          horizon_nxt = cfg_data;
          cnt_nxt     = '0;
          wp_nxt      = '0;
          sum_nxt     = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      win_len_r   <= CW'(4);
      horizon_r   <= CW'(3);
      cnt_r       <= '0;
      fc_cnt_r    <= '0;
      wp_r        <= '0;
      sum_r       <= '0;
      max_r       <= '0;
      min_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_len_r   <= win_len_nxt;
      horizon_r   <= horizon_nxt;
      cnt_r       <= cnt_nxt;
      fc_cnt_r    <= fc_cnt_nxt;
      wp_r        <= wp_nxt;
      sum_r       <= sum_nxt;
      max_r       <= max_nxt;
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_last_r <= out_last_nxt;
    out_fc_r   <= out_fc_nxt;
    out_max_r  <= out_max_nxt;
    out_min_r  <= out_min_nxt;
  end

  // Window memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[wp_r] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= win_mem[wp_r];
    end
  end

  // Sum over window length
  maf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (eff_w),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = maf_pkg::OUT_DATA_W'({out_min_r, out_max_r, out_fc_r});

  // Ring pointer stays inside the active window
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (AW+1)'(wp_r) < (AW+1)'(eff_w))
    else $error("window pointer outside active window");

  // History count never reaches the window length while loading
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (cnt_r < eff_w))
    else $error("history count overran window length");

  // Final result's extremes bracket its own forecast
  a_last_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_max_r >= out_fc_r) && (out_min_r <= out_fc_r))
    else $error("run extremes do not bracket final forecast");

  // Emitting the last forecast returns to loading with a cleared sum
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && fc_last && !cfg_xfer) |=> (state_r == S_LOAD) && (sum_r == '0) && out_valid_r)
    else $error("run did not end cleanly");

  // Divider result is only consumed after a start
  a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_START) |=> !div_done)
    else $error("stale divider result after start");

endmodule

### rtl/core/maf_div.sv
// Restoring divider, one quotient bit per cycle: window sum over window length.
// Depends on maf_pkg for widths.
module maf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [maf_pkg::SUM_W-1:0]   dividend,
  input  logic [maf_pkg::CFG_W-1:0]   divisor,
  output logic                        done,
  output logic [maf_pkg::PRICE_W-1:0] quotient
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [maf_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [maf_pkg::SUM_W-1:0]   shreg_r, shreg_nxt;
  logic [maf_pkg::CFG_W-1:0]   rem_r, rem_nxt;

  logic [maf_pkg::CFG_W:0]     rem_sh;
  logic [maf_pkg::CFG_W:0]     rem_diff;
  logic                        fits;

  // One shift-and-subtract step
  always_comb begin
    rem_sh   = {rem_r, shreg_r[maf_pkg::SUM_W-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    fits     = (rem_sh >= {1'b0, divisor});
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = done_r;
    step_nxt  = step_r;
    shreg_nxt = shreg_r;
    rem_nxt   = rem_r;
    if (start) begin
      busy_nxt  = 1'b1;
      done_nxt  = 1'b0;
      step_nxt  = '0;
      shreg_nxt = dividend;
      rem_nxt   = '0;
    end else if (busy_r) begin
      shreg_nxt = {shreg_r[maf_pkg::SUM_W-2:0], fits};
      rem_nxt   = fits ? rem_diff[maf_pkg::CFG_W-1:0] : rem_sh[maf_pkg::CFG_W-1:0];
      step_nxt  = step_r + 1'b1;
      if (step_r == maf_pkg::STEP_W'(maf_pkg::SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    shreg_r <= shreg_nxt;
    rem_r   <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = shreg_r[maf_pkg::PRICE_W-1:0];

endmodule

### bench/tb_top.sv
// Self-checking bench for moving_average_forecast: directed plan, then random histories.
// Depends on maf_pkg and the RTL top level; holds its own forecast predictor.
module tb_top;

  localparam int QUIET_CYCLES = 4;      // block settles after a burst or a load
  localparam int DRAIN_CYCLES = 40;     // extra cycles at the end for stray results
  localparam int STALL_LIMIT  = 4000;   // cycles without any transfer
  localparam int PHASE_ITEMS  = 100;

  // Indexes outside the register list; writes to them must do nothing
  localparam logic [maf_pkg::IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [maf_pkg::IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef logic [maf_pkg::PRICE_W-1:0] price_t;

  typedef struct packed {
    price_t fc;
    logic   last;
    price_t hi;
    price_t lo;
  } forecast_t;

  typedef enum logic {ROW_CFG, ROW_PRICE} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [maf_pkg::IDX_W-1:0] idx;
    price_t                    val;
    logic                      typed;   // final forecast of the burst given below
    price_t                    fc;
    price_t                    hi;
    price_t                    lo;
  } row_t;

  localparam int N_ROWS = 30;

  // Directed plan; typed rows carry the final forecast, max and min of the burst
  row_t plan [N_ROWS] = '{
    // reset settings: window 4, horizon 3
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'h000100, 1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'h000200, 1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'h000300, 1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'h000400, 1'b1, 24'h000318, 24'h000318, 24'h000280},
    // zero window and zero horizon act as 1
    '{ROW_CFG,   maf_pkg::REG_WINDOW_LEN, 24'd0,      1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_CFG,   maf_pkg::REG_HORIZON,    24'd0,      1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'h000000, 1'b1, 24'h000000, 24'h000000, 24'h000000},
    // horizon above the maximum saturates to 64
    '{ROW_CFG,   maf_pkg::REG_HORIZON,    24'd127,    1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'hABCDEF, 1'b1, 24'hABCDEF, 24'hABCDEF, 24'hABCDEF},
    // window 3, horizon 2; writes to spare indexes keep the partial history
    '{ROW_CFG,   maf_pkg::REG_WINDOW_LEN, 24'd3,      1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_CFG,   maf_pkg::REG_HORIZON,    24'd2,      1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'h000300, 1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'h000600, 1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_CFG,   REG_SPARE_2,             24'd127,    1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_CFG,   REG_SPARE_3,             24'd0,      1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'h000900, 1'b1, 24'h000700, 24'h000700, 24'h000600},
    // a register write drops the partial history
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'hFFFFFF, 1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'hFFFFFF, 1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_CFG,   maf_pkg::REG_HORIZON,    24'd2,      1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'h000300, 1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'h000600, 1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'h000900, 1'b1, 24'h000700, 24'h000700, 24'h000600},
    // mean truncates toward zero
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'h000001, 1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'h000001, 1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'h000000, 1'b1, 24'h000000, 24'h000000, 24'h000000},
    // near-full prices, checked by the predictor
    '{ROW_CFG,   maf_pkg::REG_WINDOW_LEN, 24'd2,      1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_CFG,   maf_pkg::REG_HORIZON,    24'd4,      1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'hFFFFFF, 1'b0, 24'h0, 24'h0, 24'h0},
    '{ROW_PRICE, maf_pkg::REG_WINDOW_LEN, 24'hFFFFFE, 1'b0, 24'h0, 24'h0, 24'h0}
  };

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [maf_pkg::IN_DATA_W-1:0]  in_tdata = '0;    // [23:0] price
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [maf_pkg::OUT_DATA_W-1:0] out_tdata;        // [23:0] forecast, [47:24] max,
                                                    // [71:48] min
  logic                           out_tlast;        // last_flag
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [maf_pkg::IDX_W-1:0]      cfg_index = '0;
  logic [maf_pkg::CFG_W-1:0]      cfg_data = '0;

  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int stall_count = 0;
  bit failed = 1'b0;

  // Predictor state
  logic [maf_pkg::CFG_W-1:0]  window_reg = 7'd4;
  logic [maf_pkg::CFG_W-1:0]  horizon_reg = 7'd3;
  price_t                     hist_ring [maf_pkg::WINDOW_MAX];
  logic [maf_pkg::CFG_W-1:0]  hist_count = '0;
  logic [maf_pkg::ADDR_W-1:0] hist_ptr = '0;
  logic [maf_pkg::SUM_W-1:0]  hist_sum = '0;
  forecast_t                  pending_forecasts [$];

  moving_average_forecast uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Zero means 1, anything above the cap saturates
  function automatic int clamp_len(input logic [maf_pkg::CFG_W-1:0] r, input int cap);
    if (r == '0) return 1;
    if (int'(r) > cap) return cap;
    return int'(r);
  endfunction

  function automatic price_t rand_price();
    case ($urandom_range(3))
      0: return price_t'($urandom());
      1: return price_t'($urandom_range(0, 4095));
      2: return {maf_pkg::PRICE_W{1'b1}} - price_t'($urandom_range(0, 4095));
      default: return $urandom_range(1) ? {maf_pkg::PRICE_W{1'b1}} : '0;
    endcase
  endfunction

  // Register value: mostly small, now and then zero, 64 or saturating
  function automatic logic [maf_pkg::CFG_W-1:0] rand_len(input int big_odds);
    if ($urandom_range(big_odds - 1) != 0) return maf_pkg::CFG_W'($urandom_range(0, 8));
    case ($urandom_range(3))
      0: return '0;
      1: return maf_pkg::CFG_W'(64);
      2: return maf_pkg::CFG_W'($urandom_range(65, 127));
      default: return '1;
    endcase
  endfunction

  function automatic void restart_history();
    hist_count = '0;
    hist_ptr   = '0;
    hist_sum   = '0;
  endfunction

  // Load one price; the price that completes the history queues the burst
  function automatic void absorb_price(input price_t p);
    int w;
    int h;
    price_t f;
    price_t hi;
    price_t lo;
    forecast_t r;
    w = clamp_len(window_reg, maf_pkg::WINDOW_MAX);
    h = clamp_len(horizon_reg, maf_pkg::HORIZON_MAX);
    if (int'(hist_ptr) >= w) hist_ptr = '0;
    hist_ring[hist_ptr] = p;
    hist_sum = hist_sum + p;
    hist_ptr = (int'(hist_ptr) + 1 == w) ? '0 : hist_ptr + 1'b1;
    hist_count = hist_count + 1'b1;
    if (int'(hist_count) < w) return;
    for (int i = 0; i < h; i++) begin
      f = price_t'(hist_sum / maf_pkg::SUM_W'(w));
      if (i == 0) begin
        hi = f;
        lo = f;
      end else begin
        if (f > hi) hi = f;
        if (f < lo) lo = f;
      end
      // forecast replaces the oldest value in the window
      hist_sum = hist_sum - hist_ring[hist_ptr] + f;
      hist_ring[hist_ptr] = f;
      hist_ptr = (int'(hist_ptr) + 1 == w) ? '0 : hist_ptr + 1'b1;
      r.fc   = f;
      r.last = (i == h - 1);
      r.hi   = r.last ? hi : '0;
      r.lo   = r.last ? lo : '0;
      pending_forecasts = {pending_forecasts, r};
    end
    restart_history();
  endfunction

  function automatic void check_field(input string name, input price_t want, input price_t got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Result check against the oldest expectation
  always @(posedge clk) begin : result_check
    forecast_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_forecasts.size() == 0) begin
        $error("forecast: expected none, actual %h", out_tdata[maf_pkg::PRICE_W-1:0]);
        failed = 1'b1;
      end else begin
        want = pending_forecasts.pop_front();
        check_field("forecast", want.fc, out_tdata[maf_pkg::PRICE_W-1:0]);
        check_field("last_flag", price_t'(want.last), price_t'(out_tlast));
        check_field("max_forecast", want.hi,
                    out_tdata[2*maf_pkg::PRICE_W-1:maf_pkg::PRICE_W]);
        check_field("min_forecast", want.lo,
                    out_tdata[3*maf_pkg::PRICE_W-1:2*maf_pkg::PRICE_W]);
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_gap_pct);
  end

  // Watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("** moving_average_forecast: FAILED **");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic send_price(input price_t p);
    if ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    do @(posedge clk); while (!in_tready);
    absorb_price(p);
  endtask

  task automatic wait_drained();
    while (pending_forecasts.size() != 0) @(posedge clk);
  endtask

  // Stop sending and let the block go idle before a register write
  task automatic settle();
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [maf_pkg::IDX_W-1:0] idx,
                           input logic [maf_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      maf_pkg::REG_WINDOW_LEN: begin
        window_reg = val;
        restart_history();
      end
      maf_pkg::REG_HORIZON: begin
        horizon_reg = val;
        restart_history();
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Random histories under one idling mode; some are cut short by a register write
  task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
    int sent;
    int w;
    int runs;
    int partial;
    logic [maf_pkg::CFG_W-1:0] wl;
    logic [maf_pkg::CFG_W-1:0] hl;
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      settle();
      wl = rand_len(12);
      hl = rand_len(5);
      write_reg(maf_pkg::REG_WINDOW_LEN, wl);
      write_reg(maf_pkg::REG_HORIZON, hl);
      if ($urandom_range(5) == 0) begin
        write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                  maf_pkg::CFG_W'($urandom()));
      end
      w = clamp_len(wl, maf_pkg::WINDOW_MAX);
      runs = (w > 16) ? 1 : $urandom_range(1, 4);
      repeat (runs) begin
        if (w > 1 && $urandom_range(9) == 0) begin
          partial = $urandom_range(1, w - 1);
          repeat (partial) send_price(rand_price());
          sent += partial;
          settle();
          write_reg(maf_pkg::REG_HORIZON, hl);
        end
        repeat (w) send_price(rand_price());
        sent += w;
        if ($urandom_range(7) == 0) begin
          in_tvalid <= 1'b0;
          wait_drained();
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan
    send_gap_pct = 11;
    recv_gap_pct = 71;
    for (int i = 0; i < N_ROWS; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].idx, plan[i].val[maf_pkg::CFG_W-1:0]);
      end else begin
        send_price(plan[i].val);
        if (plan[i].typed) begin
          pending_forecasts[$] = '{fc: plan[i].fc, last: 1'b1, hi: plan[i].hi, lo: plan[i].lo};
        end
      end
    end

    // Largest window with the largest horizon
    settle();
    write_reg(maf_pkg::REG_WINDOW_LEN, maf_pkg::CFG_W'(64));
    write_reg(maf_pkg::REG_HORIZON, maf_pkg::CFG_W'(64));
    repeat (64) send_price(rand_price());

    run_phase(11, 71, PHASE_ITEMS);
    run_phase(71, 11, PHASE_ITEMS);
    run_phase(0, 0, PHASE_ITEMS);

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("** moving_average_forecast: PASSED **");
    end else begin
      $display("** moving_average_forecast: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/maf_pkg.sv
rtl/core/maf_div.sv
rtl/core/moving_average_forecast.sv
bench/tb_top.sv
